>>> sv/rtpsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpsm_pkg
// Shared constants, widths, event codes and controller/datapath bundles for
// the RTP receive statistics monitor.
// ----------------------------------------------------------------------------
package rtpsm_pkg;

   // fixed point and smoothing
   localparam int FRAC_BITS    = 8;
   localparam int JITTER_SHIFT = 4;

   // field widths
   localparam int SEQ_W     = 16;
   localparam int SIZE_W    = 16;
   localparam int TIME_W    = 64;
   localparam int COUNT_W   = 32;
   localparam int TOTAL_W   = 48;
   localparam int TRANSIT_W = 32;
   localparam int MEAN_W    = 40;
   localparam int JIT_W     = 41;
   localparam int EVENT_W   = 2;

   // internal arithmetic widths
   localparam int SCL_W  = TRANSIT_W + FRAC_BITS;
   localparam int CALC_W = ((SCL_W > MEAN_W) ? SCL_W : MEAN_W) + 2;
   localparam int SUM_W  = CALC_W + 1;
   localparam int JC_W   = ((SCL_W > JIT_W) ? SCL_W : JIT_W) + 2;
   localparam int DIV_W  = COUNT_W + 1;
   localparam int CNT_W  = $clog2(CALC_W + 1);

   // stream payload widths
   localparam int REQ_DATA_W    = 3 * 16 + 2 * TIME_W;
   localparam int RSP_FIELDS_W  = 4 * COUNT_W + 3 * TOTAL_W + 2 * TRANSIT_W
                                  + MEAN_W + JIT_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   // sequence events
   localparam logic [EVENT_W-1:0] SEQ_FIRST    = 2'd0;
   localparam logic [EVENT_W-1:0] SEQ_IN_ORDER = 2'd1;
   localparam logic [EVENT_W-1:0] SEQ_GAP      = 2'd2;
   localparam logic [EVENT_W-1:0] SEQ_REORDER  = 2'd3;

   typedef struct packed {
      logic load;
      logic calc;
      logic timing;
      logic jitter;
      logic div_start;
      logic mean;
      logic publish;
   } rtpsm_cmd_type;

   typedef struct packed {
      logic timed;
      logic first;
      logic div_done;
   } rtpsm_sts_type;

   // clamp a wide signed value into the signed mean range
   function automatic logic signed [MEAN_W-1:0] sat_mean(input logic signed [SUM_W-1:0] v);
      logic all_ones;
      logic all_zeros;
      all_ones  = &v[SUM_W-1:MEAN_W-1];
      all_zeros = ~(|v[SUM_W-1:MEAN_W-1]);
      if (all_ones || all_zeros) begin
         sat_mean = v[MEAN_W-1:0];
      end else if (v[SUM_W-1]) begin
         sat_mean = {1'b1, {(MEAN_W-1){1'b0}}};
      end else begin
         sat_mean = {1'b0, {(MEAN_W-1){1'b1}}};
      end
   endfunction

endpackage

>>> sv/rtpsm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpsm_div
// Restoring unsigned divider, one quotient bit per cycle, used for the
// running mean update.
// ----------------------------------------------------------------------------
module rtpsm_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rtpsm_pkg::CALC_W-1:0]     dividend,
   input  logic [rtpsm_pkg::DIV_W-1:0]      divisor,
   output logic                             done,
   output logic [rtpsm_pkg::CALC_W-1:0]     quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [rtpsm_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [rtpsm_pkg::DIV_W-1:0]      rem_ff, rem_in;
   logic [rtpsm_pkg::DIV_W-1:0]      dvs_ff, dvs_in;
   logic [rtpsm_pkg::CALC_W-1:0]     quo_ff, quo_in;
   logic [rtpsm_pkg::DIV_W:0]        shifted;
   logic [rtpsm_pkg::DIV_W+1:0]      trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[rtpsm_pkg::CALC_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = rtpsm_pkg::CNT_W'(rtpsm_pkg::CALC_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // subtract only when no borrow comes out
         if (!trial[rtpsm_pkg::DIV_W+1]) begin
            rem_in = trial[rtpsm_pkg::DIV_W-1:0];
            quo_in = {quo_ff[rtpsm_pkg::CALC_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[rtpsm_pkg::DIV_W-1:0];
            quo_in = {quo_ff[rtpsm_pkg::CALC_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - rtpsm_pkg::CNT_W'(1);
         if (cnt_ff == rtpsm_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/rtpsm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpsm_dp
// Statistics datapath: packet capture, totals, sequence check, transit,
// min/max, jitter, running mean and the result register.
// ----------------------------------------------------------------------------
module rtpsm_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rtpsm_pkg::rtpsm_cmd_type             cmd,
   output rtpsm_pkg::rtpsm_sts_type             sts,
   input  logic [rtpsm_pkg::SEQ_W-1:0]          sequence_number,
   input  logic [rtpsm_pkg::SIZE_W-1:0]         packet_bytes,
   input  logic [rtpsm_pkg::SIZE_W-1:0]         payload_bytes,
   input  logic                                 has_send_time,
   input  logic [rtpsm_pkg::TIME_W-1:0]         send_time_us,
   input  logic [rtpsm_pkg::TIME_W-1:0]         now_us,
   output logic [rtpsm_pkg::RSP_DATA_W-1:0]     rsp_data,
   output logic [rtpsm_pkg::EVENT_W-1:0]        rsp_event
);

   localparam int TW = rtpsm_pkg::TRANSIT_W;

   // captured packet
   logic [rtpsm_pkg::SEQ_W-1:0]        seq_ff;
   logic [rtpsm_pkg::SIZE_W-1:0]       pbytes_ff;
   logic [rtpsm_pkg::SIZE_W-1:0]       plbytes_ff;
   logic                               timed_ff;
   logic [rtpsm_pkg::TIME_W-1:0]       send_ff;
   logic [rtpsm_pkg::TIME_W-1:0]       now_ff;

   // statistics
   logic [rtpsm_pkg::COUNT_W-1:0]      packets_ff, packets_in;
   logic [rtpsm_pkg::TOTAL_W-1:0]      bytes_ff, bytes_in;
   logic [rtpsm_pkg::TOTAL_W-1:0]      payload_ff, payload_in;
   logic [rtpsm_pkg::COUNT_W-1:0]      tcount_ff, tcount_in;
   logic signed [TW-1:0]               min_ff, min_in;
   logic signed [TW-1:0]               max_ff, max_in;
   logic signed [rtpsm_pkg::MEAN_W-1:0] mean_ff, mean_in;
   logic [rtpsm_pkg::JIT_W-1:0]        jit_ff, jit_in;
   logic                               have_prev_ff, have_prev_in;
   logic signed [TW-1:0]               prev_ff, prev_in;
   logic                               have_exp_ff, have_exp_in;
   logic [rtpsm_pkg::SEQ_W-1:0]        exp_ff, exp_in;
   logic [rtpsm_pkg::COUNT_W-1:0]      gaps_ff, gaps_in;
   logic [rtpsm_pkg::TOTAL_W-1:0]      lost_ff, lost_in;
   logic [rtpsm_pkg::COUNT_W-1:0]      reorder_ff, reorder_in;

   // work registers
   logic [rtpsm_pkg::EVENT_W-1:0]      event_ff, event_in;
   logic signed [TW-1:0]               transit_ff, transit_in;
   logic                               first_ff, first_in;
   logic                               jit_en_ff, jit_en_in;
   logic [TW-1:0]                      absd_ff, absd_in;
   logic signed [rtpsm_pkg::CALC_W-1:0] diff_ff, diff_in;

   // result register
   logic [rtpsm_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [rtpsm_pkg::EVENT_W-1:0]      rsp_event_ff, rsp_event_in;

   // combinational helpers
   logic signed [rtpsm_pkg::TIME_W:0]  tdiff;
   logic [rtpsm_pkg::SEQ_W-1:0]        seq_delta;
   logic signed [rtpsm_pkg::SCL_W-1:0] scaled;
   logic signed [TW:0]                 pdiff;
   logic [rtpsm_pkg::JC_W-1:0]         jabs;
   logic signed [rtpsm_pkg::JC_W-1:0]  jstep;
   logic signed [rtpsm_pkg::JC_W-1:0]  jnew;
   logic [rtpsm_pkg::CALC_W-1:0]       dividend;
   logic [rtpsm_pkg::DIV_W-1:0]        divisor;
   logic                               div_done;
   logic [rtpsm_pkg::CALC_W-1:0]       quotient;
   logic signed [rtpsm_pkg::SUM_W-1:0] mean_sum;

   rtpsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      tdiff     = $signed({1'b0, now_ff}) - $signed({1'b0, send_ff});
      seq_delta = seq_ff - exp_ff;
      scaled    = rtpsm_pkg::SCL_W'(transit_ff) <<< rtpsm_pkg::FRAC_BITS;
      pdiff     = (TW + 1)'(transit_ff) - (TW + 1)'(prev_ff);
      jabs      = rtpsm_pkg::JC_W'(absd_ff) << rtpsm_pkg::FRAC_BITS;
      jstep     = $signed(jabs) - $signed(rtpsm_pkg::JC_W'(jit_ff));
      jnew      = $signed(rtpsm_pkg::JC_W'(jit_ff)) + (jstep >>> rtpsm_pkg::JITTER_SHIFT);
      dividend  = diff_ff[rtpsm_pkg::CALC_W-1] ? rtpsm_pkg::CALC_W'(-diff_ff)
                                               : rtpsm_pkg::CALC_W'(diff_ff);
      // a wrapped timing count divides by 2^32
      divisor   = {(tcount_ff == '0), tcount_ff};
      if (diff_ff[rtpsm_pkg::CALC_W-1]) begin
         mean_sum = rtpsm_pkg::SUM_W'(mean_ff) - $signed(rtpsm_pkg::SUM_W'(quotient));
      end else begin
         mean_sum = rtpsm_pkg::SUM_W'(mean_ff) + $signed(rtpsm_pkg::SUM_W'(quotient));
      end
   end

   always_comb begin
      packets_in   = packets_ff;
      bytes_in     = bytes_ff;
      payload_in   = payload_ff;
      tcount_in    = tcount_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      mean_in      = mean_ff;
      jit_in       = jit_ff;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      have_exp_in  = have_exp_ff;
      exp_in       = exp_ff;
      gaps_in      = gaps_ff;
      lost_in      = lost_ff;
      reorder_in   = reorder_ff;
      event_in     = event_ff;
      transit_in   = transit_ff;
      first_in     = first_ff;
      jit_en_in    = jit_en_ff;
      absd_in      = absd_ff;
      diff_in      = diff_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_event_in = rsp_event_ff;

      if (cmd.calc) begin
         packets_in = packets_ff + rtpsm_pkg::COUNT_W'(1);
         bytes_in   = bytes_ff + rtpsm_pkg::TOTAL_W'(pbytes_ff);
         payload_in = payload_ff + rtpsm_pkg::TOTAL_W'(plbytes_ff);
         // saturate the exact difference to signed 32 bits
         if ((&tdiff[rtpsm_pkg::TIME_W:TW-1]) || ~(|tdiff[rtpsm_pkg::TIME_W:TW-1])) begin
            transit_in = tdiff[TW-1:0];
         end else if (tdiff[rtpsm_pkg::TIME_W]) begin
            transit_in = {1'b1, {(TW-1){1'b0}}};
         end else begin
            transit_in = {1'b0, {(TW-1){1'b1}}};
         end
         if (!have_exp_ff) begin
            have_exp_in = 1'b1;
            exp_in      = seq_ff + rtpsm_pkg::SEQ_W'(1);
            event_in    = rtpsm_pkg::SEQ_FIRST;
         end else if (seq_delta == '0) begin
            exp_in   = seq_ff + rtpsm_pkg::SEQ_W'(1);
            event_in = rtpsm_pkg::SEQ_IN_ORDER;
         end else if (!seq_delta[rtpsm_pkg::SEQ_W-1]) begin
            gaps_in  = gaps_ff + rtpsm_pkg::COUNT_W'(1);
            lost_in  = lost_ff + rtpsm_pkg::TOTAL_W'(seq_delta);
            exp_in   = seq_ff + rtpsm_pkg::SEQ_W'(1);
            event_in = rtpsm_pkg::SEQ_GAP;
         end else begin
            // half-range jump lands here too
            reorder_in = reorder_ff + rtpsm_pkg::COUNT_W'(1);
            event_in   = rtpsm_pkg::SEQ_REORDER;
         end
      end

      if (cmd.timing) begin
         tcount_in = tcount_ff + rtpsm_pkg::COUNT_W'(1);
         first_in  = (tcount_ff == '0);
         if (tcount_ff == '0) begin
            min_in  = transit_ff;
            max_in  = transit_ff;
            mean_in = rtpsm_pkg::sat_mean(rtpsm_pkg::SUM_W'(scaled));
         end else begin
            if (transit_ff < min_ff) begin
               min_in = transit_ff;
            end
            if (transit_ff > max_ff) begin
               max_in = transit_ff;
            end
         end
         diff_in      = rtpsm_pkg::CALC_W'(scaled) - rtpsm_pkg::CALC_W'(mean_ff);
         absd_in      = pdiff[TW] ? TW'(-pdiff) : pdiff[TW-1:0];
         jit_en_in    = have_prev_ff;
         prev_in      = transit_ff;
         have_prev_in = 1'b1;
      end

      if (cmd.jitter && jit_en_ff) begin
         if (jnew[rtpsm_pkg::JC_W-1]) begin
            jit_in = '0;
         end else if (|jnew[rtpsm_pkg::JC_W-2:rtpsm_pkg::JIT_W]) begin
            jit_in = '1;
         end else begin
            jit_in = jnew[rtpsm_pkg::JIT_W-1:0];
         end
      end

      if (cmd.mean) begin
         mean_in = rtpsm_pkg::sat_mean(mean_sum);
      end

      if (cmd.publish) begin
         rsp_data_in  = rtpsm_pkg::RSP_DATA_W'({reorder_ff, lost_ff, gaps_ff, jit_ff,
                                                 mean_ff, max_ff, min_ff, tcount_ff,
                                                 payload_ff, bytes_ff, packets_ff});
         rsp_event_in = event_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packets_ff   <= '0;
         bytes_ff     <= '0;
         payload_ff   <= '0;
         tcount_ff    <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         mean_ff      <= '0;
         jit_ff       <= '0;
         have_prev_ff <= 1'b0;
         prev_ff      <= '0;
         have_exp_ff  <= 1'b0;
         exp_ff       <= '0;
         gaps_ff      <= '0;
         lost_ff      <= '0;
         reorder_ff   <= '0;
         first_ff     <= 1'b0;
         jit_en_ff    <= 1'b0;
      end else begin
         packets_ff   <= packets_in;
         bytes_ff     <= bytes_in;
         payload_ff   <= payload_in;
         tcount_ff    <= tcount_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         mean_ff      <= mean_in;
         jit_ff       <= jit_in;
         have_prev_ff <= have_prev_in;
         prev_ff      <= prev_in;
         have_exp_ff  <= have_exp_in;
         exp_ff       <= exp_in;
         gaps_ff      <= gaps_in;
         lost_ff      <= lost_in;
         reorder_ff   <= reorder_in;
         first_ff     <= first_in;
         jit_en_ff    <= jit_en_in;
      end
      if (cmd.load) begin
         seq_ff     <= sequence_number;
         pbytes_ff  <= packet_bytes;
         plbytes_ff <= payload_bytes;
         timed_ff   <= has_send_time;
         send_ff    <= send_time_us;
         now_ff     <= now_us;
      end
      event_ff     <= event_in;
      transit_ff   <= transit_in;
      absd_ff      <= absd_in;
      diff_ff      <= diff_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_event_ff <= rsp_event_in;
   end

   assign sts.timed    = timed_ff;
   assign sts.first    = first_ff;
   assign sts.div_done = div_done;
   assign rsp_data     = rsp_data_ff;
   assign rsp_event    = rsp_event_ff;

endmodule

>>> sv/rtpsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpsm_ctrl
// Sequencer for one packet update and the result stream handshake.
// ----------------------------------------------------------------------------
module rtpsm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output rtpsm_pkg::rtpsm_cmd_type  cmd,
   input  rtpsm_pkg::rtpsm_sts_type  sts
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CALC = 3'd1;
   localparam logic [2:0] ST_TIME = 3'd2;
   localparam logic [2:0] ST_JIT  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_MEAN = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cmd      = '0;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = sts.timed ? ST_TIME : ST_DONE;
         end
         ST_TIME: begin
            cmd.timing = 1'b1;
            state_in   = ST_JIT;
         end
         ST_JIT: begin
            cmd.jitter = 1'b1;
            if (sts.first) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            cmd.mean = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               valid_in    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

endmodule

>>> sv/rtp_receive_stats_monitor.sv
`timescale 1ns / 1ps
// Sequence: a packet without send time is loaded, calculated and published;
//   the first timed packet adds the timing and jitter steps; later timed
//   packets also run the restoring mean divider (one quotient bit per cycle,
//   42 steps) and the mean update. Publishing waits while the output
//   register still holds an unaccepted result.
// Packets are taken one at a time, in the idle state only; the next packet is
//   taken while the previous result waits in the output register.
// Reset: synchronous, clears every statistic and the sequence tracking.
// ----------------------------------------------------------------------------
// rtp_receive_stats_monitor
// Running receive statistics per RTP packet: totals, transit min/max/mean,
// smoothed jitter and sequence gap, loss and reorder counts.
// ----------------------------------------------------------------------------
module rtp_receive_stats_monitor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sequence_number, packet_bytes, payload_bytes, send_time_us, now_us
   input  logic [rtpsm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // has_send_time
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // packets_total, bytes_total, payload_total, timed_packets, min_latency,
   // max_latency, mean_latency, jitter_estimate, gap_count, lost_estimate,
   // reorder_count, zero fill
   output logic [rtpsm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // seq_event
   output logic [rtpsm_pkg::EVENT_W-1:0]        rsp_tuser
);

   rtpsm_pkg::rtpsm_cmd_type cmd;
   rtpsm_pkg::rtpsm_sts_type sts;

   rtpsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   rtpsm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .sequence_number (req_tdata[15:0]),
      .packet_bytes    (req_tdata[31:16]),
      .payload_bytes   (req_tdata[47:32]),
      .has_send_time   (req_tuser),
      .send_time_us    (req_tdata[111:48]),
      .now_us          (req_tdata[175:112]),
      .rsp_data        (rsp_tdata),
      .rsp_event       (rsp_tuser)
   );

endmodule
